>>> src/qte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helper functions for the quaternion to
// Euler angle block.
// ---------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int TAB_IDX_W    = 5;
  localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // cordic vector and angle accumulator widths
  localparam int CW = 36;
  localparam int ZW = 30;
  // square root operand width
  localparam int SQW = 61;
  // working width for angle fixups
  localparam int AW = 22;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = ZW'(26353589);
  localparam logic signed [17:0]   HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [AW-1:0] TWO_PI_Q13  = AW'(51472);
  localparam logic signed [AW-1:0] SAT_MAX     = AW'(131071);
  localparam logic signed [AW-1:0] SAT_MIN     = -AW'(131072);

  typedef logic signed [15:0] q_t;
  typedef logic signed [17:0] angle_t;
  typedef logic [1:0]         status_t;

  localparam status_t ST_NORMAL = 2'd0;
  localparam status_t ST_NORTH  = 2'd1;
  localparam status_t ST_SOUTH  = 2'd2;

  localparam logic REG_POLE_THR   = 1'b0;
  localparam logic REG_UNWRAP_THR = 1'b1;

  function automatic logic [23:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
    logic [23:0] r;
    case (idx)
      5'd0:  r = 24'd13176795;
      5'd1:  r = 24'd7778716;
      5'd2:  r = 24'd4110060;
      5'd3:  r = 24'd2086331;
      5'd4:  r = 24'd1047214;
      5'd5:  r = 24'd524117;
      5'd6:  r = 24'd262123;
      5'd7:  r = 24'd131069;
      5'd8:  r = 24'd65536;
      5'd9:  r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  // round a Q.24 angle to Q9.13
  function automatic logic signed [AW-1:0] q24_to_q13(input logic signed [32:0] z);
    logic signed [32:0] t;
    t = z + 33'sd1024;
    return $signed(t[32:11]);
  endfunction

  function automatic angle_t sat18(input logic signed [AW-1:0] v);
    angle_t r;
    if (v > SAT_MAX) r = 18'sd131071;
    else if (v < SAT_MIN) r = -18'sd131072;
    else r = v[17:0];
    return r;
  endfunction

  function automatic angle_t unwrap(input angle_t prev, input logic signed [AW-1:0] v,
                                    input logic [15:0] th);
    logic signed [AW-1:0] vv;
    logic signed [AW-1:0] pp;
    logic signed [AW-1:0] tt;
    pp = AW'(prev);
    tt = $signed({{(AW-16){1'b0}}, th});
    vv = v;
    if (pp - vv > tt) vv = vv + TWO_PI_Q13;
    if (pp - vv < -tt) vv = vv - TWO_PI_Q13;
    return sat18(vv);
  endfunction

endpackage
`default_nettype wire

>>> src/qte_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qte_if
// Valid/ready channels: quaternion samples in, Euler angle results out.
// ---------------------------------------------------------------------------
interface qte_in_if;
  import qte_pkg::*;
  logic valid;
  logic ready;
  q_t   q_real;
  q_t   q_i;
  q_t   q_j;
  q_t   q_k;
  modport source (output valid, q_real, q_i, q_j, q_k, input ready);
  modport sink   (input valid, q_real, q_i, q_j, q_k, output ready);
endinterface

interface qte_out_if;
  import qte_pkg::*;
  logic    valid;
  logic    ready;
  angle_t  out_roll;
  angle_t  out_pitch;
  angle_t  out_yaw;
  status_t pole_status;
  modport source (output valid, out_roll, out_pitch, out_yaw, pole_status, input ready);
  modport sink   (input valid, out_roll, out_pitch, out_yaw, pole_status, output ready);
endinterface
`default_nettype wire

>>> src/quaternion_to_euler_unwrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quaternion_to_euler_unwrap
// Unit quaternion to roll, pitch and yaw with pole handling and 2pi unwrap.
// ---------------------------------------------------------------------------
// One word is taken at a time. A normal word goes through the products on
// the shared multiplier, the pole test and squaring, the 31-step square
// root of the attitude, then three CORDIC passes (bank, attitude, heading)
// on one shared CORDIC unit, each of start, 16 steps and done, and then
// unwrap and output load. A word near a pole needs one CORDIC pass only.
// The block is ready again in the same cycle that the result is loaded. The
// result sits in an output register, so the next word is accepted while the
// previous result waits.
// The user must write thresholds through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce this.
module quaternion_to_euler_unwrap (
  input  logic        clk,
  input  logic        rst,
  qte_in_if.sink      sample,
  qte_out_if.source   result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import qte_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_TEST = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SQST = 4'd4;
  localparam logic [3:0] S_SQW  = 4'd5;
  localparam logic [3:0] S_CST  = 4'd6;
  localparam logic [3:0] S_CW   = 4'd7;
  localparam logic [3:0] S_UNW  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [1:0] J_POLE = 2'd0;
  localparam logic [1:0] J_BANK = 2'd1;
  localparam logic [1:0] J_ATT  = 2'd2;
  localparam logic [1:0] J_HEAD = 2'd3;

  logic [3:0]  state;
  logic [3:0]  cnt;
  logic [1:0]  job;
  logic        south;

  logic [14:0] pole_threshold;
  logic [15:0] unwrap_threshold;

  q_t qa, qb, qc, qd;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] preg [9];

  logic signed [32:0] test;
  logic signed [32:0] lim;
  logic signed [33:0] s2;
  logic signed [31:0] s_reg;
  logic [30:0]        r_reg;

  logic signed [CW-1:0] c_y, c_x;
  logic                 c_start, c_done;
  logic signed [ZW-1:0] c_z;
  logic                 q_start, q_done;
  logic [SQW-1:0]       q_v;
  logic [30:0]          q_root;

  logic signed [AW-1:0] bank_raw, att_raw, z_q13;
  logic signed [32:0]   z2;
  angle_t bank_f, att_f, head_f;
  angle_t prev_bank, prev_attitude, prev_heading;
  status_t status_f;

  logic    out_valid;
  angle_t  o_roll, o_pitch, o_yaw;
  status_t o_status;

  assign sample.ready       = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.out_roll    = o_roll;
  assign result.out_pitch   = o_pitch;
  assign result.out_yaw     = o_yaw;
  assign result.pole_status = o_status;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      mul_a = s_reg;
      mul_b = s_reg;
    end else if (state == S_MUL) begin
      case (cnt)
        4'd0: begin mul_a = 32'(qc); mul_b = 32'(qb); end
        4'd1: begin mul_a = 32'(qd); mul_b = 32'(qa); end
        4'd2: begin mul_a = 32'(qb); mul_b = 32'(qa); end
        4'd3: begin mul_a = 32'(qc); mul_b = 32'(qd); end
        4'd4: begin mul_a = 32'(qb); mul_b = 32'(qb); end
        4'd5: begin mul_a = 32'(qd); mul_b = 32'(qd); end
        4'd6: begin mul_a = 32'(qc); mul_b = 32'(qa); end
        4'd7: begin mul_a = 32'(qb); mul_b = 32'(qd); end
        4'd8: begin mul_a = 32'(qc); mul_b = 32'(qc); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign test = 33'(preg[0]) + 33'(preg[1]);
  assign lim  = $signed({3'b000, pole_threshold, 15'b0});
  assign s2   = 34'(test) <<< 1;

  // cordic operands for the current job
  always_comb begin
    case (job)
      J_POLE: begin
        c_y = CW'(qc) <<< 15;
        c_x = CW'(qa) <<< 15;
      end
      J_BANK: begin
        c_y = CW'(preg[2]) - CW'(preg[3]);
        c_x = CW'(1 << 29) - CW'(preg[4]) - CW'(preg[5]);
      end
      J_ATT: begin
        c_y = CW'(s_reg);
        c_x = CW'({1'b0, r_reg});
      end
      J_HEAD: begin
        c_y = CW'(preg[6]) - CW'(preg[7]);
        c_x = CW'(1 << 29) - CW'(preg[8]) - CW'(preg[5]);
      end
      default: begin
        c_y = '0;
        c_x = '0;
      end
    endcase
  end

  assign c_start = (state == S_CST);
  assign q_start = (state == S_SQST);
  assign q_v     = (SQW'(1) << (SQW - 1)) - prod[SQW-1:0];
  assign z_q13   = q24_to_q13(33'(c_z));
  assign z2      = south ? -(33'(c_z) <<< 1) : (33'(c_z) <<< 1);

  qte_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .y_in  (c_y),
    .x_in  (c_x),
    .done  (c_done),
    .z     (c_z)
  );

  qte_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (q_start),
    .v_in  (q_v),
    .done  (q_done),
    .root  (q_root)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == S_MUL) begin
      for (int j = 0; j < 9; j++) begin
        if (cnt == 4'(j + 1)) preg[j] <= prod[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cnt              <= '0;
      job              <= J_POLE;
      south            <= 1'b0;
      out_valid        <= 1'b0;
      pole_threshold   <= 15'd16381;
      unwrap_threshold <= 16'd50041;
      prev_bank        <= '0;
      prev_attitude    <= '0;
      prev_heading     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLE_THR:   pole_threshold   <= cfg_data[14:0];
          REG_UNWRAP_THR: unwrap_threshold <= cfg_data;
          default: ;
        endcase
      end
      // the output load below owns out_valid in the done state
      if (out_valid && result.ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            qa    <= sample.q_real;
            qb    <= sample.q_i;
            qc    <= sample.q_j;
            qd    <= sample.q_k;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'd9) state <= S_TEST;
        end
        S_TEST: begin
          if (test > lim || test < -lim) begin
            south <= !(test > lim);
            job   <= J_POLE;
            state <= S_CST;
          end else begin
            // asin argument clamped to [-1, 1]
            if (s2 > 34'sd1073741824) s_reg <= 32'sd1073741824;
            else if (s2 < -34'sd1073741824) s_reg <= -32'sd1073741824;
            else s_reg <= s2[31:0];
            state <= S_SQ;
          end
        end
        S_SQ:   state <= S_SQST;
        S_SQST: state <= S_SQW;
        S_SQW: begin
          if (q_done) begin
            r_reg <= q_root;
            job   <= J_BANK;
            state <= S_CST;
          end
        end
        S_CST: state <= S_CW;
        S_CW: begin
          if (c_done) begin
            case (job)
              J_POLE: begin
                bank_f   <= sat18(q24_to_q13(z2));
                att_f    <= south ? -HALF_PI_Q13 : HALF_PI_Q13;
                head_f   <= '0;
                status_f <= south ? ST_SOUTH : ST_NORTH;
                state    <= S_DONE;
              end
              J_BANK: begin
                bank_raw <= z_q13;
                job      <= J_ATT;
                state    <= S_CST;
              end
              J_ATT: begin
                att_raw <= z_q13;
                job     <= J_HEAD;
                state   <= S_CST;
              end
              J_HEAD: begin
                bank_f   <= unwrap(prev_bank, bank_raw, unwrap_threshold);
                att_f    <= unwrap(prev_attitude, att_raw, unwrap_threshold);
                head_f   <= unwrap(prev_heading, z_q13, unwrap_threshold);
                status_f <= ST_NORMAL;
                state    <= S_UNW;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_UNW: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || result.ready) begin
            o_roll        <= sat18(-AW'(bank_f));
            o_pitch       <= head_f;
            o_yaw         <= att_f;
            o_status      <= status_f;
            out_valid     <= 1'b1;
            prev_bank     <= bank_f;
            prev_attitude <= att_f;
            prev_heading  <= head_f;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("word accepted while a word is in flight");

  a_north_angles: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_status == ST_NORTH) |-> (o_yaw == HALF_PI_Q13 && o_pitch == '0))
    else $error("north pole result with wrong fixed angles");

  a_cordic_wait: assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == S_CW))
    else $error("cordic finished outside its wait state");

endmodule
`default_nettype wire

>>> src/qte_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qte_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle, atan2 in Q.24.
// ---------------------------------------------------------------------------
module qte_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [qte_pkg::CW-1:0] y_in,
  input  logic signed [qte_pkg::CW-1:0] x_in,
  output logic                         done,
  output logic signed [qte_pkg::ZW-1:0] z
);
  import qte_pkg::*;

  logic                  run;
  logic [ITER_W-1:0]     iter;
  logic signed [CW-1:0]  x;
  logic signed [CW-1:0]  y;
  logic signed [CW-1:0]  dx;
  logic signed [CW-1:0]  dy;
  logic signed [ZW-1:0]  ang;

  assign dx  = x >>> iter;
  assign dy  = y >>> iter;
  assign ang = $signed({{(ZW-24){1'b0}}, atan_q24(TAB_IDX_W'(iter))});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        iter <= '0;
        if (x_in == '0 && y_in == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          // fold the left half plane onto the right
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x <= y_in;
              y <= -x_in;
              z <= HALF_PI_Q24;
            end else begin
              x <= -y_in;
              y <= x_in;
              z <= -HALF_PI_Q24;
            end
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end
      end else if (run) begin
        if (y > 0) begin
          x <= x + dy;
          y <= y - dx;
          z <= z + ang;
        end else begin
          x <= x - dy;
          y <= y + dx;
          z <= z - ang;
        end
        iter <= iter + 1'b1;
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !run)
    else $error("cordic started while busy");

endmodule
`default_nettype wire

>>> src/qte_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qte_isqrt
// Iterative integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module qte_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [qte_pkg::SQW-1:0] v_in,
  output logic                   done,
  output logic [30:0]            root
);
  import qte_pkg::*;

  logic           run;
  logic [SQW-1:0] v;
  logic [SQW-1:0] res;
  logic [SQW-1:0] bitv;
  logic [SQW-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= v_in;
        res  <= '0;
        bitv <= SQW'(1) << (SQW - 1);
        run  <= 1'b1;
      end else if (run) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sim/qte_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qte_checker
// Watches the sample and result channels and predicts each result from the
// accepted quaternion. It keeps its own threshold and previous-angle state
// and compares every result word, field by field, against the oldest
// prediction. The mismatch count goes to the top level.
// ---------------------------------------------------------------------------
module qte_checker (
  input  logic        clk,
  input  logic        rst,
  qte_in_if.sink      sample,
  qte_out_if.sink     result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          n_results,
  output int          n_poles
);
  import qte_pkg::*;

  typedef struct packed {
    angle_t  roll;
    angle_t  pitch;
    angle_t  yaw;
    status_t status;
  } angles_t;

  localparam longint HALF_PI_Z  = 64'sd26353589;
  localparam longint HALF_PI_A  = 64'sd12868;
  localparam longint TWO_PI_A   = 64'sd51472;
  localparam longint ONE_Q30    = 64'sd1073741824;

  angles_t      expected_q[$];
  logic [14:0]  pole_thr;
  logic [15:0]  wrap_thr;
  longint       last_bank, last_att, last_head;

  function automatic longint atan_step(input int i);
    longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                      131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  function automatic longint clamp18(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint round_q13(input longint z);
    return (z + 1024) >>> 11;
  endfunction

  function automatic longint root64(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vec_angle(input longint y, input longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Z;
      end else begin
        x = -y; y = t; z = -HALF_PI_Z;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x += dy; y -= dx; z += atan_step(i);
      end else begin
        x -= dy; y += dx; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint rewrap(input longint prev, input longint v);
    longint th;
    th = longint'(wrap_thr);
    if (prev - v > th) v += TWO_PI_A;
    if (prev - v < -th) v -= TWO_PI_A;
    return clamp18(v);
  endfunction

  function automatic angles_t predict_angles(input q_t qr, input q_t qi, input q_t qj,
                                             input q_t qk);
    longint a, b, c, d, test, lim, z, s, r, bank, att, head;
    angles_t o;
    a = qr; b = qi; c = qj; d = qk;
    test = c * b + d * a;
    lim = longint'(pole_thr) * 32768;
    if (test > lim || test < -lim) begin
      z = vec_angle(c * 32768, a * 32768);
      if (test > lim) begin
        bank = clamp18(round_q13(2 * z)); att = HALF_PI_A; o.status = ST_NORTH;
      end else begin
        bank = clamp18(round_q13(-2 * z)); att = -HALF_PI_A; o.status = ST_SOUTH;
      end
      head = 0;
    end else begin
      s = 2 * test;
      if (s > ONE_Q30) s = ONE_Q30;
      if (s < -ONE_Q30) s = -ONE_Q30;
      r = root64((64'sd1 << 60) - s * s);
      bank = round_q13(vec_angle(b * a - c * d, ONE_Q30 / 2 - b * b - d * d));
      att  = round_q13(vec_angle(s, r));
      head = round_q13(vec_angle(c * a - b * d, ONE_Q30 / 2 - c * c - d * d));
      bank = rewrap(last_bank, bank);
      att  = rewrap(last_att, att);
      head = rewrap(last_head, head);
      o.status = ST_NORMAL;
    end
    last_bank = bank; last_att = att; last_head = head;
    o.roll  = angle_t'(clamp18(-bank));
    o.pitch = angle_t'(head);
    o.yaw   = angle_t'(att);
    return o;
  endfunction

  always @(posedge clk) begin
    angles_t e;
    int      bad;
    if (rst) begin
      pole_thr <= 15'd16381;
      wrap_thr <= 16'd50041;
      last_bank = 0; last_att = 0; last_head = 0;
      expected_q.delete();
      errors <= 0; n_results <= 0; n_poles <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (cfg_we) begin
        if (cfg_index == REG_POLE_THR) pole_thr <= cfg_data[14:0];
        else wrap_thr <= cfg_data;
      end
      if (result.valid && result.ready) begin
        n_results <= n_results + 1;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          bad++;
        end else begin
          e = expected_q.pop_front();
          if (e.status != ST_NORMAL) n_poles <= n_poles + 1;
          if (result.out_roll !== e.roll) begin
            $error("out_roll expected %0d got %0d", e.roll, result.out_roll);
            bad++;
          end
          if (result.out_pitch !== e.pitch) begin
            $error("out_pitch expected %0d got %0d", e.pitch, result.out_pitch);
            bad++;
          end
          if (result.out_yaw !== e.yaw) begin
            $error("out_yaw expected %0d got %0d", e.yaw, result.out_yaw);
            bad++;
          end
          if (result.pole_status !== e.status) begin
            $error("pole_status expected %0d got %0d", e.status, result.pole_status);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
      if (sample.valid && sample.ready)
        expected_q.push_back(predict_angles(sample.q_real, sample.q_i, sample.q_j,
                                            sample.q_k));
      pending <= expected_q.size();
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_quaternion_to_euler_unwrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tb_quaternion_to_euler_unwrap
// Drives quaternion words through the block under bursty input and a
// stalling output, across several threshold settings, and reports the
// verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_quaternion_to_euler_unwrap;
  import qte_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          errors, pending, n_results, n_poles;
  int          idle_cycles = 0;
  int          n_sent = 0;
  logic        stall_mode = 1'b0;

  qte_in_if  sample();
  qte_out_if result();

  quaternion_to_euler_unwrap i_dut (
    .clk, .rst, .sample(sample.sink), .result(result.source),
    .cfg_we, .cfg_index, .cfg_data
  );

  qte_checker i_checker (
    .clk, .rst, .sample(sample.sink), .result(result.sink),
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .n_results, .n_poles
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    sample.valid = 1'b0;
    sample.q_real = '0; sample.q_i = '0; sample.q_j = '0; sample.q_k = '0;
    result.ready = 1'b0;
  end

  // receiver stall pattern: phases of mostly ready and heavy stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    if (stall_mode) result.ready <= ($urandom_range(0, 3) == 0);
    else result.ready <= ($urandom_range(0, 7) != 0);
  end

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d words pending", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // a word sent without keep closes its burst by dropping valid
  task automatic send_word(input q_t qr, input q_t qi, input q_t qj, input q_t qk,
                           input bit keep);
    sample.valid  <= 1'b1;
    sample.q_real <= qr; sample.q_i <= qi; sample.q_j <= qj; sample.q_k <= qk;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    n_sent++;
    if (!keep) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // roughly unit quaternion from a random direction, sometimes raw noise
  task automatic random_word(input bit keep, input int pole_bias);
    int c[4];
    longint n;
    real sc;
    if ($urandom_range(0, 9) == 0) begin
      send_word(q_t'($urandom), q_t'($urandom), q_t'($urandom), q_t'($urandom), keep);
    end else begin
      for (int i = 0; i < 4; i++) c[i] = $urandom_range(0, 60000) - 30000;
      if ($urandom_range(0, 99) < pole_bias) begin
        // pole bias: i set close to real and j to +/- k
        c[1] = c[0]; c[2] = ($urandom_range(0, 1) ? c[3] : -c[3]);
        c[1] += $urandom_range(0, 200) - 100;
      end
      n = 0;
      for (int i = 0; i < 4; i++) n += longint'(c[i]) * c[i];
      if (n == 0) n = 1;
      sc = 32767.0 / $sqrt(real'(n));
      send_word(q_t'($rtoi(c[0] * sc)), q_t'($rtoi(c[1] * sc)),
                q_t'($rtoi(c[2] * sc)), q_t'($rtoi(c[3] * sc)), keep);
    end
  endtask

  task automatic random_phase(input int count, input int pole_bias);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && count > 0; i++) begin
        count--;
        random_word(i < burst - 1 && count > 0, pole_bias);
      end
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] pole_set[5] = '{16'd16381, 16'd0, 16'd16384, 16'd12000, 16'h7FFF};
    logic [15:0] wrap_set[5] = '{16'd50041, 16'd0, 16'd51472, 16'd20000, 16'hFFFF};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, poles, zero vector, non-unit and unwrap flips
    send_word(16'sd32767, 0, 0, 0, 1'b0);
    send_word(0, 0, 0, 0, 1'b0);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_word(16'sd23170, 0, 0, 16'sd23170, 1'b0);
    send_word(16'sd23170, 0, 0, -16'sd23170, 1'b0);
    send_word(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1);
    send_word(-16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384, 1'b1);
    send_word(0, 16'sd32767, 0, 0, 1'b1);
    send_word(0, -16'sd32768, 0, 0, 1'b1);
    send_word(0, 16'sd100, 0, 0, 1'b1);
    send_word(0, -16'sd100, 0, 0, 1'b1);
    send_word(-16'sd32768, 0, 16'sd100, 0, 1'b1);
    send_word(-16'sd32768, 0, -16'sd100, 0, 1'b1);
    send_word(0, 0, 16'sd32767, 0, 1'b1);
    send_word(0, 0, 0, 16'sd32767, 1'b1);
    send_word(16'sd5, 16'sd5, 16'sd32767, 16'sd5, 1'b1);
    send_word(-16'sd23170, -16'sd23170, 0, 0, 1'b1);
    send_word(16'sd23170, 16'sd23170, 0, 0, 1'b1);
    send_word(-16'sd23170, 16'sd23170, 0, 0, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_POLE_THR, pole_set[p]);
      write_reg(REG_UNWRAP_THR, wrap_set[p]);
      if (p == 1) begin
        // zero thresholds: every nonzero test is a pole, unwrap fires on any change
        send_word(16'sd100, 0, 0, 0, 1'b0);
        send_word(16'sd100, 0, 0, 16'sd1, 1'b0);
      end
      random_phase(p == 0 ? 650 : 200, p == 3 ? 40 : 15);
      drain();
    end

    $display("sent %0d quaternion words, checked %0d results (%0d at a pole)",
             n_sent, n_results, n_poles);
    $display("covered five threshold settings including both extremes");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
src/qte_pkg.sv
src/qte_if.sv
src/qte_cordic.sv
src/qte_isqrt.sv
src/quaternion_to_euler_unwrap.sv
sim/qte_checker.sv
sim/tb_quaternion_to_euler_unwrap.sv
